FILE: rtl/neb_pkg.sv
package neb_pkg;

   localparam int KEEP_TONES    = 3;
   localparam int FOLD_LOW      = 35;
   localparam int HI_N          = KEEP_TONES - 1;
   localparam int HI_IW         = (HI_N > 1) ? $clog2(HI_N) : 1;
   localparam int HI_CW         = $clog2(HI_N + 1);
   localparam int FOLD_UP_STEPS = (FOLD_LOW + 11) / 12;
   localparam int FOLD_DN_STEPS = (127 - (FOLD_LOW + 63) + 11) / 12;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;

   localparam logic [11:0] MAX_TICKS    = 12'd3528;
   localparam logic [11:0] DELAY_STEP   = 12'd63;
   localparam logic [3:0]  DRUM_CHANNEL = 4'd9;

   localparam logic [7:0] BYTE_DELAY_FULL = 8'h7F;
   localparam logic [7:0] BYTE_DELAY_REST = 8'h40;
   localparam logic [7:0] BYTE_END        = 8'hFF;
   localparam logic [7:0] NOISE_NONE      = 8'h00;

   localparam logic [7:0] NOISE_CRASH = 8'hBC;
   localparam logic [7:0] NOISE_RIDE  = 8'hB5;
   localparam logic [7:0] NOISE_SNARE = 8'h84;
   localparam logic [7:0] NOISE_BASS  = 8'h86;
   localparam logic [7:0] NOISE_LTOM  = 8'h82;
   localparam logic [7:0] NOISE_MTOM  = 8'h81;
   localparam logic [7:0] NOISE_HTOM  = 8'h80;
   localparam logic [7:0] NOISE_OHAT  = 8'hB4;
   localparam logic [7:0] NOISE_CHAT  = 8'hA5;

   localparam int DC_CRASH = 0;
   localparam int DC_RIDE  = 1;
   localparam int DC_SNARE = 2;
   localparam int DC_BASS  = 3;
   localparam int DC_LTOM  = 4;
   localparam int DC_MTOM  = 5;
   localparam int DC_HTOM  = 6;
   localparam int DC_OHAT  = 7;
   localparam int DC_CHAT  = 8;
   localparam int DC_N     = 9;

   typedef enum logic [1:0] {
      REQ_DELAY = 2'd0,
      REQ_NOTE  = 2'd1,
      REQ_END   = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic accept;
      logic emit_delay;
      logic emit_lo;
      logic emit_hi;
      logic emit_noise;
      logic emit_end;
   } neb_cmd_type;

   typedef struct packed {
      logic delay_pend;
      logic lo_pend;
      logic hi_pend;
      logic noise_pend;
      logic end_pend;
      logic out_free;
   } neb_status_type;

   function automatic logic [5:0] fold_note(input logic [6:0] note);
      logic [7:0] v;
      v = {1'b0, note};
      for (int i = 0; i < FOLD_UP_STEPS; i++) begin
         if (v < 8'(FOLD_LOW)) begin
            v = v + 8'd12;
         end
      end
      for (int i = 0; i < FOLD_DN_STEPS; i++) begin
         if (v > 8'(FOLD_LOW + 63)) begin
            v = v - 8'd12;
         end
      end
      return 6'(v - 8'(FOLD_LOW));
   endfunction

   function automatic logic [DC_N-1:0] drum_class(input logic [6:0] note);
      logic [DC_N-1:0] m;
      m = '0;
      case (note)
         7'd49, 7'd57: begin
            m[DC_CRASH] = 1'b1;
         end
         7'd51, 7'd59: begin
            m[DC_RIDE] = 1'b1;
         end
         7'd37, 7'd38, 7'd39, 7'd40, 7'd52: begin
            m[DC_SNARE] = 1'b1;
         end
         7'd55: begin
            m[DC_SNARE] = 1'b1;
            m[DC_OHAT]  = 1'b1;
         end
         7'd35, 7'd36, 7'd41, 7'd45: begin
            m[DC_BASS] = 1'b1;
         end
         7'd47, 7'd61, 7'd64, 7'd66, 7'd68, 7'd77: begin
            m[DC_LTOM] = 1'b1;
         end
         7'd48, 7'd60, 7'd62, 7'd63, 7'd65, 7'd67, 7'd76: begin
            m[DC_MTOM] = 1'b1;
         end
         7'd50, 7'd56, 7'd71, 7'd72, 7'd80, 7'd81: begin
            m[DC_HTOM] = 1'b1;
         end
         7'd46, 7'd53, 7'd54, 7'd58, 7'd70: begin
            m[DC_OHAT] = 1'b1;
         end
         7'd42, 7'd44: begin
            m[DC_CHAT] = 1'b1;
         end
         default: begin
            m = '0;
         end
      endcase
      return m;
   endfunction

   function automatic logic [7:0] noise_pick(input logic [DC_N-1:0] flags);
      logic [7:0] c;
      c = NOISE_NONE;
      if (flags[DC_CRASH]) begin
         c = NOISE_CRASH;
      end else if (flags[DC_RIDE]) begin
         c = NOISE_RIDE;
      end else if (flags[DC_SNARE]) begin
         c = NOISE_SNARE;
      end else if (flags[DC_BASS]) begin
         c = NOISE_BASS;
      end else if (flags[DC_LTOM]) begin
         c = NOISE_LTOM;
      end else if (flags[DC_MTOM]) begin
         c = NOISE_MTOM;
      end else if (flags[DC_HTOM]) begin
         c = NOISE_HTOM;
      end else if (flags[DC_OHAT]) begin
         c = NOISE_OHAT;
      end else if (flags[DC_CHAT]) begin
         c = NOISE_CHAT;
      end
      return c;
   endfunction

endpackage

FILE: rtl/note_event_byte_encoder.sv
// A taken request's bytes go out in order: delay bytes, the lowest tone, the upper tone
// bytes, a noise byte and the end byte, each loaded into the registered result output.
// The byte sequencer emits one byte a cycle while the result channel is free; a stalled
// result channel holds it. Only one request is in work at a time; the last byte may wait
// while the next request is taken. Synchronous active-high reset empties the event state.
module note_event_byte_encoder
   import neb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [11:0] delay_ticks, [15:12] channel, [22:16] note_number, [29:23] velocity
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] out_byte
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   neb_cmd_type    cmd;
   neb_status_type status;

   neb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   neb_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/neb_ctrl.sv
module neb_ctrl
   import neb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  neb_status_type status,
   output neb_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DELAY  = 6'b000010,
      ST_LOW    = 6'b000100,
      ST_HIGH   = 6'b001000,
      ST_NOISE  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DELAY;
            end
         end
         ST_DELAY: begin
            if (!status.delay_pend) begin
               state_in = ST_LOW;
            end else if (status.out_free) begin
               cmd.emit_delay = 1'b1;
            end
         end
         ST_LOW: begin
            if (!status.lo_pend) begin
               state_in = ST_HIGH;
            end else if (status.out_free) begin
               cmd.emit_lo = 1'b1;
               state_in    = ST_HIGH;
            end
         end
         ST_HIGH: begin
            if (!status.hi_pend) begin
               state_in = ST_NOISE;
            end else if (status.out_free) begin
               cmd.emit_hi = 1'b1;
            end
         end
         ST_NOISE: begin
            if (!status.noise_pend) begin
               state_in = ST_FINISH;
            end else if (status.out_free) begin
               cmd.emit_noise = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.end_pend) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/neb_dpath.sv
module neb_dpath
   import neb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  neb_cmd_type           cmd,
   output neb_status_type        status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic [11:0]   req_delay;
   logic [3:0]    req_channel;
   logic [6:0]    req_note;
   logic [6:0]    req_velocity;
   req_kind_type  req_kind;
   logic [11:0]   dt;
   logic [12:0]   ext_sum;

   logic            open_ff, open_in;
   logic            first_ff, first_in;
   logic [11:0]     pending_ff, pending_in;
   logic            tones_any_ff, tones_any_in;
   logic [6:0]      lo_ff, lo_in;
   logic [6:0]      hi_ff [HI_N];
   logic [6:0]      hi_in [HI_N];
   logic [HI_CW-1:0] hi_cnt_ff, hi_cnt_in;
   logic [DC_N-1:0] drums_ff, drums_in;

   logic [11:0]     cnt_ff, cnt_in;
   logic            snap_lo_valid_ff, snap_lo_valid_in;
   logic [6:0]      snap_lo_ff, snap_lo_in;
   logic [6:0]      snap_hi_ff [HI_N];
   logic [6:0]      snap_hi_in [HI_N];
   logic [HI_CW-1:0] snap_cnt_ff, snap_cnt_in;
   logic [7:0]      snap_noise_ff, snap_noise_in;
   logic            end_pend_ff, end_pend_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            dup;
   logic [HI_CW-1:0] pos;
   logic [6:0]      hi_ins [HI_N];
   logic [HI_CW-1:0] hi_cnt_ins;
   logic [6:0]      lo_ins;
   logic [HI_CW-1:0] snap_cnt_cl;
   logic [HI_CW-1:0] snap_dec;
   logic            close_go;
   logic            delay_go;
   logic            end_go;
   logic            rest_after_delay;
   logic            load;

   assign req_delay    = req_tdata[11:0];
   assign req_channel  = req_tdata[15:12];
   assign req_note     = req_tdata[22:16];
   assign req_velocity = req_tdata[29:23];
   assign req_kind     = req_kind_type'(req_tuser);
   assign dt           = (req_delay > MAX_TICKS) ? MAX_TICKS : req_delay;
   assign ext_sum      = {1'b0, pending_ff} + {1'b0, dt};

   // A note counts as present when it is the lowest tone or in the high list;
   // a note that is already present changes neither.
   always_comb begin
      dup         = tones_any_ff && (lo_ff == req_note);
      pos         = '0;
      snap_cnt_cl = '0;
      for (int i = 0; i < HI_N; i++) begin
         if (HI_CW'(i) < hi_cnt_ff) begin
            if (hi_ff[i] == req_note) begin
               dup = 1'b1;
            end
            if (hi_ff[i] > req_note) begin
               pos = pos + 1'b1;
            end
            if (hi_ff[i] != lo_ff) begin
               snap_cnt_cl = snap_cnt_cl + 1'b1;
            end
         end
      end
      for (int i = 0; i < HI_N; i++) begin
         if (HI_CW'(i) < pos) begin
            hi_ins[i] = hi_ff[i];
         end else if (HI_CW'(i) == pos) begin
            hi_ins[i] = req_note;
         end else begin
            hi_ins[i] = hi_ff[(i > 0) ? i - 1 : 0];
         end
      end
      hi_cnt_ins = (hi_cnt_ff == HI_CW'(HI_N)) ? hi_cnt_ff : hi_cnt_ff + 1'b1;
      lo_ins     = (!tones_any_ff || (req_note < lo_ff)) ? req_note : lo_ff;
   end

   assign snap_dec         = snap_cnt_ff - 1'b1;
   assign rest_after_delay = snap_lo_valid_ff || (snap_cnt_ff != '0) ||
                             (snap_noise_ff != NOISE_NONE) || end_pend_ff;
   assign load             = cmd.emit_delay || cmd.emit_lo || cmd.emit_hi ||
                             cmd.emit_noise || cmd.emit_end;

   always_comb begin
      open_in          = open_ff;
      first_in         = first_ff;
      pending_in       = pending_ff;
      tones_any_in     = tones_any_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      hi_cnt_in        = hi_cnt_ff;
      drums_in         = drums_ff;
      cnt_in           = cnt_ff;
      snap_lo_valid_in = snap_lo_valid_ff;
      snap_lo_in       = snap_lo_ff;
      snap_hi_in       = snap_hi_ff;
      snap_cnt_in      = snap_cnt_ff;
      snap_noise_in    = snap_noise_ff;
      end_pend_in      = end_pend_ff;
      rsp_byte_in      = rsp_byte_ff;
      rsp_last_in      = rsp_last_ff;
      close_go         = 1'b0;
      delay_go         = 1'b0;
      end_go           = 1'b0;

      if (cmd.accept) begin
         case (req_kind)
            REQ_DELAY: begin
               if (open_ff && !tones_any_ff) begin
                  pending_in = (ext_sum > {1'b0, MAX_TICKS}) ? MAX_TICKS : ext_sum[11:0];
               end else begin
                  if (open_ff) begin
                     close_go = 1'b1;
                     first_in = 1'b0;
                  end
                  open_in    = 1'b1;
                  pending_in = dt;
               end
            end
            REQ_NOTE: begin
               if (req_velocity != 7'd0) begin
                  if (!open_ff) begin
                     open_in    = 1'b1;
                     pending_in = '0;
                  end
                  if (req_channel == DRUM_CHANNEL) begin
                     drums_in = drums_ff | drum_class(req_note);
                  end else begin
                     delay_go = !tones_any_ff && !first_ff;
                     if (!dup) begin
                        tones_any_in = 1'b1;
                        lo_in        = lo_ins;
                        hi_in        = hi_ins;
                        hi_cnt_in    = hi_cnt_ins;
                     end
                  end
               end
            end
            REQ_END: begin
               if (open_ff) begin
                  close_go = 1'b1;
                  delay_go = !tones_any_ff && !first_ff;
               end
               end_go     = 1'b1;
               open_in    = 1'b0;
               first_in   = 1'b1;
               pending_in = '0;
            end
            default: begin
            end
         endcase

         cnt_in           = delay_go ? pending_ff : '0;
         snap_lo_valid_in = close_go && tones_any_ff;
         snap_lo_in       = lo_ff;
         snap_hi_in       = hi_ff;
         snap_cnt_in      = close_go ? snap_cnt_cl : '0;
         snap_noise_in    = close_go ? noise_pick(drums_ff) : NOISE_NONE;
         end_pend_in      = end_go;
         if (close_go || end_go) begin
            tones_any_in = 1'b0;
            hi_cnt_in    = '0;
            drums_in     = '0;
         end
      end

      if (cmd.emit_delay) begin
         if (cnt_ff > DELAY_STEP) begin
            rsp_byte_in = BYTE_DELAY_FULL;
            rsp_last_in = 1'b0;
            cnt_in      = cnt_ff - DELAY_STEP;
         end else begin
            rsp_byte_in = BYTE_DELAY_REST | {2'b00, cnt_ff[5:0]};
            rsp_last_in = !rest_after_delay;
            cnt_in      = '0;
         end
      end
      if (cmd.emit_lo) begin
         rsp_byte_in      = {2'b00, fold_note(snap_lo_ff)};
         rsp_last_in      = !((snap_cnt_ff != '0) || (snap_noise_ff != NOISE_NONE) ||
                              end_pend_ff);
         snap_lo_valid_in = 1'b0;
      end
      if (cmd.emit_hi) begin
         rsp_byte_in = {2'b00, fold_note(snap_hi_ff[snap_dec[HI_IW-1:0]])};
         rsp_last_in = !((snap_dec != '0) || (snap_noise_ff != NOISE_NONE) || end_pend_ff);
         snap_cnt_in = snap_dec;
      end
      if (cmd.emit_noise) begin
         rsp_byte_in   = snap_noise_ff;
         rsp_last_in   = !end_pend_ff;
         snap_noise_in = NOISE_NONE;
      end
      if (cmd.emit_end) begin
         rsp_byte_in = BYTE_END;
         rsp_last_in = 1'b1;
         end_pend_in = 1'b0;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff          <= 1'b0;
         first_ff         <= 1'b1;
         pending_ff       <= '0;
         tones_any_ff     <= 1'b0;
         hi_cnt_ff        <= '0;
         drums_ff         <= '0;
         cnt_ff           <= '0;
         snap_lo_valid_ff <= 1'b0;
         snap_cnt_ff      <= '0;
         snap_noise_ff    <= NOISE_NONE;
         end_pend_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         open_ff          <= open_in;
         first_ff         <= first_in;
         pending_ff       <= pending_in;
         tones_any_ff     <= tones_any_in;
         hi_cnt_ff        <= hi_cnt_in;
         drums_ff         <= drums_in;
         cnt_ff           <= cnt_in;
         snap_lo_valid_ff <= snap_lo_valid_in;
         snap_cnt_ff      <= snap_cnt_in;
         snap_noise_ff    <= snap_noise_in;
         end_pend_ff      <= end_pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      snap_lo_ff  <= snap_lo_in;
      snap_hi_ff  <= snap_hi_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.delay_pend = cnt_ff != '0;
   assign status.lo_pend    = snap_lo_valid_ff;
   assign status.hi_pend    = snap_cnt_ff != '0;
   assign status.noise_pend = snap_noise_ff != NOISE_NONE;
   assign status.end_pend   = end_pend_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/neb_checker.sv
module neb_checker
   import neb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == BYTE_END) |-> rsp_tlast)
      else $error("end byte not marked last");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in work");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind note_event_byte_encoder neb_checker u_neb_checker (.*);
